[src/els_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// els_pkg
// Types and codes shared by the engine launch sequencer modules.
// ----------------------------------------------------------------------------
package els_pkg;

  localparam int unsigned MaxResults = 8;
  localparam int unsigned IdxW = 3;

  localparam logic [1:0] KIND_WAKE   = 2'd0;
  localparam logic [1:0] KIND_LAUNCH = 2'd1;
  localparam logic [1:0] KIND_MANUAL = 2'd2;
  localparam logic [1:0] KIND_PRESS  = 2'd3;

  localparam logic [2:0] ACT_NOW     = 3'd0;
  localparam logic [2:0] ACT_DELAYED = 3'd1;
  localparam logic [2:0] ACT_ABORT   = 3'd2;
  localparam logic [2:0] ACT_BEGIN   = 3'd3;
  localparam logic [2:0] ACT_END     = 3'd4;
  localparam logic [2:0] ACT_WAKE    = 3'd5;
  localparam logic [2:0] ACT_ACCEPT  = 3'd6;
  localparam logic [2:0] ACT_REJECT  = 3'd7;

  localparam logic [2:0] CH_IGN   = 3'd0;
  localparam logic [2:0] CH_ARM   = 3'd1;
  localparam logic [2:0] CH_NOS   = 3'd2;
  localparam logic [2:0] CH_IPA   = 3'd3;
  localparam logic [2:0] CH_PRESS = 3'd4;
  localparam logic [2:0] CH_VENT  = 3'd5;

  localparam logic [2:0] ABT_BURN_NOT_BURNT = 3'd0;
  localparam logic [2:0] ABT_BREAK_EARLY    = 3'd1;
  localparam logic [2:0] ABT_IGNITER        = 3'd2;
  localparam logic [2:0] ABT_BURNWIRE       = 3'd3;
  localparam logic [2:0] ABT_BREAKWIRE      = 3'd4;

  localparam logic [2:0] STEP_IGNITE  = 3'd0;
  localparam logic [2:0] STEP_BURN    = 3'd1;
  localparam logic [2:0] STEP_OPEN    = 3'd2;
  localparam logic [2:0] STEP_CHECK   = 3'd3;
  localparam logic [2:0] STEP_END     = 3'd4;

  localparam logic [31:0] WAKE_SHORT_US  = 32'd10;
  localparam logic [9:0]  MS_TO_US       = 10'd1000;
  localparam logic [31:0] ABORT_EXTRA_MS = 32'd100;

  localparam logic [2:0] REG_CART      = 3'd0;
  localparam logic [2:0] REG_IGN_TMO   = 3'd1;
  localparam logic [2:0] REG_BURN_DLY  = 3'd2;
  localparam logic [2:0] REG_SAMPLE    = 3'd3;
  localparam logic [2:0] REG_NOS_DLY   = 3'd4;
  localparam logic [2:0] REG_IPA_DLY   = 3'd5;
  localparam logic [2:0] REG_ARM_DLY   = 3'd6;
  localparam logic [2:0] REG_THRESHOLD = 3'd7;

  typedef enum logic [4:0] {
    OP_IGN_ON,
    OP_IGN_OFF,
    OP_ABORT,
    OP_BEGIN,
    OP_END,
    OP_WAKE,
    OP_ACCEPT,
    OP_REJECT,
    OP_ARM_ON,
    OP_NOS_DLY_ON,
    OP_IPA_DLY_ON,
    OP_PRESS_POP,
    OP_VENT_POP,
    OP_NOS_OFF,
    OP_IPA_OFF,
    OP_NOS_DLY_ABT,
    OP_IPA_DLY_ABT,
    OP_ARM_DLY_OFF,
    OP_PRESS_OFF,
    OP_VENT_ON,
    OP_PRESS_POP_ABT,
    OP_VENT_POP_ABT,
    OP_NOS_DLY_OFF,
    OP_IPA_DLY_OFF,
    OP_PRESS_DLY_NOS,
    OP_VENT_DLY_IPA
  } op_t;

  typedef struct packed {
    op_t [MaxResults-1:0] ops;
    logic [IdxW-1:0]      cnt;
    logic [31:0]          wake;
    logic [2:0]           abort_code;
    logic [2:0]           mode;
    logic [22:0]          flow_ms;
    logic                 nitrous;
    logic                 ipa;
  } job_t;

  typedef struct packed {
    logic        cart_variant;
    logic [31:0] igniter_timeout_us;
    logic [31:0] burnwire_delay_us;
    logic [31:0] sample_period_us;
    logic [15:0] nos_main_delay_ms;
    logic [15:0] ipa_main_delay_ms;
    logic [15:0] arm_close_delay_ms;
    logic [19:0] pressure_threshold;
  } cfg_t;

endpackage
`default_nettype wire

[src/els_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// els_front
// Accepts transactions, runs the flow steps and queues a result job for each one but pressure samples.
// ----------------------------------------------------------------------------
module els_front #(
  parameter int unsigned IGNITION_CHECK_MS = 700
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire els_pkg::cfg_t    cfg,
  input  wire logic             accept,
  input  wire logic [1:0]       kind,
  input  wire logic [31:0]      now_us,
  input  wire logic             igniter_ok,
  input  wire logic             burnwire_ok,
  input  wire logic             breakwire_ok,
  input  wire logic [2:0]       mode,
  input  wire logic [22:0]      flow_ms,
  input  wire logic             nitrous_en,
  input  wire logic             ipa_en,
  input  wire logic [19:0]      pressure,
  output els_pkg::job_t         job,
  output logic                  push
);
  import els_pkg::*;

  localparam logic [31:0] IGN_CHECK_US = 32'(IGNITION_CHECK_MS * 1000);

  logic [2:0]  step, step_next;
  logic [31:0] start_time, start_time_next;
  logic [2:0]  latched_mode, latched_mode_next;
  logic [22:0] latched_flow_ms, latched_flow_ms_next;
  logic [31:0] flow_us, flow_us_next;
  logic        nitrous_armed, nitrous_armed_next;
  logic        ipa_armed, ipa_armed_next;
  logic        manual_start, manual_start_next;
  logic [19:0] chamber_pressure, chamber_pressure_next;

  op_t [MaxResults-1:0] ops;
  logic [IdxW:0]        n;
  logic [31:0]          wake;
  logic [2:0]           code;
  logic                 igm, igm_new;
  logic [31:0]          el, el_sum;

  always_comb begin
    step_next             = step;
    start_time_next       = start_time;
    latched_mode_next     = latched_mode;
    latched_flow_ms_next  = latched_flow_ms;
    flow_us_next          = flow_us;
    nitrous_armed_next    = nitrous_armed;
    ipa_armed_next        = ipa_armed;
    manual_start_next     = manual_start;
    chamber_pressure_next = chamber_pressure;
    ops     = {MaxResults{OP_WAKE}};
    n       = '0;
    wake    = '0;
    code    = ABT_BURN_NOT_BURNT;
    push    = 1'b0;
    igm     = (latched_mode <= 3'd2);
    igm_new = (mode <= 3'd2);
    el      = now_us - start_time;
    el_sum  = el + cfg.sample_period_us;
    unique case (kind)
      KIND_PRESS: begin
        chamber_pressure_next = pressure;
      end
      KIND_WAKE: begin
        push = 1'b1;
        unique case (step)
          STEP_IGNITE: begin
            if (igm) begin
              ops[n[IdxW-1:0]] = OP_IGN_ON; n = n + 1'b1;
              step_next       = STEP_BURN;
              start_time_next = now_us;
              wake            = cfg.sample_period_us;
            end else begin
              step_next = STEP_OPEN;
              wake      = WAKE_SHORT_US;
            end
          end
          STEP_BURN: begin
            if (el > cfg.igniter_timeout_us) begin
              ops[n[IdxW-1:0]] = OP_IGN_OFF; n = n + 1'b1;
              ops[n[IdxW-1:0]] = OP_ABORT; n = n + 1'b1;
              code      = ABT_BURN_NOT_BURNT;
              step_next = STEP_IGNITE;
            end else if (!burnwire_ok) begin
              step_next = STEP_OPEN;
              wake      = cfg.burnwire_delay_us;
            end else begin
              wake = cfg.sample_period_us;
            end
          end
          STEP_OPEN: begin
            if (!manual_start) begin
              if (igm) begin
                ops[n[IdxW-1:0]] = OP_IGN_OFF; n = n + 1'b1;
              end
              ops[n[IdxW-1:0]] = OP_BEGIN; n = n + 1'b1;
            end else begin
              ops[n[IdxW-1:0]] = OP_IGN_OFF; n = n + 1'b1;
            end
            if (cfg.cart_variant) begin
              ops[n[IdxW-1:0]] = OP_ARM_ON; n = n + 1'b1;
              if (nitrous_armed) begin
                ops[n[IdxW-1:0]] = OP_NOS_DLY_ON; n = n + 1'b1;
                nitrous_armed_next = 1'b0;
              end
              if (ipa_armed) begin
                ops[n[IdxW-1:0]] = OP_IPA_DLY_ON; n = n + 1'b1;
                ipa_armed_next = 1'b0;
              end
            end else if (nitrous_armed && ipa_armed) begin
              ops[n[IdxW-1:0]] = OP_PRESS_POP; n = n + 1'b1;
              ops[n[IdxW-1:0]] = OP_VENT_POP; n = n + 1'b1;
              nitrous_armed_next = 1'b0;
              ipa_armed_next     = 1'b0;
            end
            manual_start_next = 1'b0;
            if (igm) begin
              step_next       = STEP_CHECK;
              start_time_next = now_us;
              wake            = WAKE_SHORT_US;
            end else begin
              step_next = STEP_END;
              wake      = flow_us;
            end
          end
          STEP_CHECK: begin
            if (flow_us <= el) begin
              step_next = STEP_END;
              wake      = WAKE_SHORT_US;
            end else if ((flow_us < el_sum) ||
                         (chamber_pressure > cfg.pressure_threshold) ||
                         (el > IGN_CHECK_US)) begin
              step_next = STEP_END;
              wake      = flow_us - el;
            end else if (!breakwire_ok) begin
              ops[n[IdxW-1:0]] = OP_ABORT; n = n + 1'b1;
              code = ABT_BREAK_EARLY;
              if (cfg.cart_variant) begin
                ops[n[IdxW-1:0]] = OP_ARM_ON; n = n + 1'b1;
                ops[n[IdxW-1:0]] = OP_NOS_OFF; n = n + 1'b1;
                ops[n[IdxW-1:0]] = OP_IPA_OFF; n = n + 1'b1;
                ops[n[IdxW-1:0]] = OP_NOS_DLY_ABT; n = n + 1'b1;
                ops[n[IdxW-1:0]] = OP_IPA_DLY_ABT; n = n + 1'b1;
                ops[n[IdxW-1:0]] = OP_ARM_DLY_OFF; n = n + 1'b1;
              end else begin
                ops[n[IdxW-1:0]] = OP_PRESS_OFF; n = n + 1'b1;
                ops[n[IdxW-1:0]] = OP_VENT_ON; n = n + 1'b1;
                ops[n[IdxW-1:0]] = OP_PRESS_POP_ABT; n = n + 1'b1;
                ops[n[IdxW-1:0]] = OP_VENT_POP_ABT; n = n + 1'b1;
              end
              step_next = STEP_IGNITE;
            end else begin
              wake = cfg.sample_period_us;
            end
          end
          STEP_END: begin
            ops[n[IdxW-1:0]] = OP_END; n = n + 1'b1;
            if (cfg.cart_variant) begin
              ops[n[IdxW-1:0]] = OP_ARM_ON; n = n + 1'b1;
              ops[n[IdxW-1:0]] = OP_NOS_DLY_OFF; n = n + 1'b1;
              ops[n[IdxW-1:0]] = OP_IPA_DLY_OFF; n = n + 1'b1;
              ops[n[IdxW-1:0]] = OP_ARM_DLY_OFF; n = n + 1'b1;
            end else begin
              ops[n[IdxW-1:0]] = OP_PRESS_DLY_NOS; n = n + 1'b1;
              ops[n[IdxW-1:0]] = OP_VENT_DLY_IPA; n = n + 1'b1;
            end
            step_next          = STEP_IGNITE;
            nitrous_armed_next = 1'b0;
            ipa_armed_next     = 1'b0;
          end
          default: begin
            wake = '0;
          end
        endcase
        ops[n[IdxW-1:0]] = OP_WAKE; n = n + 1'b1;
      end
      default: begin
        push                 = 1'b1;
        latched_mode_next    = mode;
        latched_flow_ms_next = flow_ms;
        flow_us_next         = 32'(flow_ms) * 32'(MS_TO_US);
        nitrous_armed_next   = nitrous_en;
        ipa_armed_next       = ipa_en;
        if (kind == KIND_MANUAL) begin
          step_next         = STEP_OPEN;
          manual_start_next = 1'b1;
          ops[n[IdxW-1:0]] = OP_ACCEPT; n = n + 1'b1;
        end else if (igm_new && (!igniter_ok || !burnwire_ok || !breakwire_ok)) begin
          if (!igniter_ok) code = ABT_IGNITER;
          else if (!burnwire_ok) code = ABT_BURNWIRE;
          else code = ABT_BREAKWIRE;
          ops[n[IdxW-1:0]] = OP_ABORT; n = n + 1'b1;
          ops[n[IdxW-1:0]] = OP_REJECT; n = n + 1'b1;
        end else begin
          step_next = STEP_IGNITE;
          ops[n[IdxW-1:0]] = OP_ACCEPT; n = n + 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    job.ops        = ops;
    job.cnt        = IdxW'(n - 1'b1);
    job.wake       = wake;
    job.abort_code = code;
    job.mode       = (kind == KIND_WAKE) ? latched_mode : mode;
    job.flow_ms    = latched_flow_ms;
    job.nitrous    = nitrous_armed;
    job.ipa        = ipa_armed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step             <= STEP_IGNITE;
      start_time       <= '0;
      latched_mode     <= '0;
      latched_flow_ms  <= '0;
      flow_us          <= '0;
      nitrous_armed    <= 1'b0;
      ipa_armed        <= 1'b0;
      manual_start     <= 1'b0;
      chamber_pressure <= 20'd14400;
    end else if (accept) begin
      step             <= step_next;
      start_time       <= start_time_next;
      latched_mode     <= latched_mode_next;
      latched_flow_ms  <= latched_flow_ms_next;
      flow_us          <= flow_us_next;
      nitrous_armed    <= nitrous_armed_next;
      ipa_armed        <= ipa_armed_next;
      manual_start     <= manual_start_next;
      chamber_pressure <= chamber_pressure_next;
    end
  end

endmodule
`default_nettype wire

[src/els_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// els_queue
// Small show-ahead job queue between the front and back parts.
// ----------------------------------------------------------------------------
module els_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire els_pkg::job_t wdata,
  input  wire logic          rd,
  output els_pkg::job_t      rdata,
  output logic               full,
  output logic               nonempty
);
  import els_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [PtrW-1:0] wptr, rptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= (wptr == PtrW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (rd) rptr <= (rptr == PtrW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CntW'(DEPTH))
    else $error("queue count over depth");
  assert property (@(posedge clk) disable iff (rst) rd |-> nonempty)
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (rst) wr |-> !full || rd)
    else $error("queue write while full");

endmodule
`default_nettype wire

[src/els_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// els_back
// Expands queued jobs into result transactions, one per cycle unless result_stall holds the output.
// ----------------------------------------------------------------------------
module els_back #(
  parameter int unsigned POPPET_DELAY_MS = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire els_pkg::cfg_t cfg,
  input  wire els_pkg::job_t head,
  input  wire logic          head_valid,
  output logic               pop,
  output logic               result_valid,
  input  wire logic          result_stall,
  output logic [2:0]         action,
  output logic [2:0]         channel,
  output logic               level,
  output logic [31:0]        delay_value,
  output logic [2:0]         abort_code,
  output logic [2:0]         flow_mode,
  output logic [22:0]        flow_time,
  output logic               flow_nitrous,
  output logic               flow_ipa,
  output logic               last
);
  import els_pkg::*;

  localparam logic [31:0] POP_MS = 32'(POPPET_DELAY_MS);

  logic [IdxW-1:0] idx;
  logic            load;
  logic [2:0]      act_c, ch_c, code_c, fmode_c;
  logic            lvl_c, nit_c, ipa_c;
  logic [31:0]     dly_c;
  logic [22:0]     ftime_c;

  assign load = head_valid && (!result_valid || !result_stall);
  assign pop  = load && (idx == head.cnt);

  always_comb begin
    act_c   = ACT_NOW;
    ch_c    = CH_IGN;
    lvl_c   = 1'b0;
    dly_c   = '0;
    code_c  = '0;
    fmode_c = '0;
    ftime_c = '0;
    nit_c   = 1'b0;
    ipa_c   = 1'b0;
    unique case (head.ops[idx])
      OP_IGN_ON:  begin ch_c = CH_IGN; lvl_c = 1'b1; end
      OP_IGN_OFF: begin ch_c = CH_IGN; end
      OP_ABORT: begin
        act_c = ACT_ABORT; code_c = head.abort_code; fmode_c = head.mode;
      end
      OP_BEGIN: begin
        act_c = ACT_BEGIN; fmode_c = head.mode; ftime_c = head.flow_ms;
        nit_c = head.nitrous; ipa_c = head.ipa;
      end
      OP_END:    act_c = ACT_END;
      OP_WAKE:   begin act_c = ACT_WAKE; dly_c = head.wake; end
      OP_ACCEPT: act_c = ACT_ACCEPT;
      OP_REJECT: act_c = ACT_REJECT;
      OP_ARM_ON: begin ch_c = CH_ARM; lvl_c = 1'b1; end
      OP_NOS_DLY_ON: begin
        act_c = ACT_DELAYED; ch_c = CH_NOS; lvl_c = 1'b1;
        dly_c = 32'(cfg.nos_main_delay_ms);
      end
      OP_IPA_DLY_ON: begin
        act_c = ACT_DELAYED; ch_c = CH_IPA; lvl_c = 1'b1;
        dly_c = 32'(cfg.ipa_main_delay_ms);
      end
      OP_PRESS_POP: begin act_c = ACT_DELAYED; ch_c = CH_PRESS; dly_c = POP_MS; end
      OP_VENT_POP: begin
        act_c = ACT_DELAYED; ch_c = CH_VENT; lvl_c = 1'b1; dly_c = POP_MS;
      end
      OP_NOS_OFF: ch_c = CH_NOS;
      OP_IPA_OFF: ch_c = CH_IPA;
      OP_NOS_DLY_ABT: begin
        act_c = ACT_DELAYED; ch_c = CH_NOS;
        dly_c = 32'(cfg.nos_main_delay_ms) + ABORT_EXTRA_MS;
      end
      OP_IPA_DLY_ABT: begin
        act_c = ACT_DELAYED; ch_c = CH_IPA;
        dly_c = 32'(cfg.ipa_main_delay_ms) + ABORT_EXTRA_MS;
      end
      OP_ARM_DLY_OFF: begin
        act_c = ACT_DELAYED; ch_c = CH_ARM; dly_c = 32'(cfg.arm_close_delay_ms);
      end
      OP_PRESS_OFF: ch_c = CH_PRESS;
      OP_VENT_ON:   begin ch_c = CH_VENT; lvl_c = 1'b1; end
      OP_PRESS_POP_ABT: begin
        act_c = ACT_DELAYED; ch_c = CH_PRESS; dly_c = POP_MS + ABORT_EXTRA_MS;
      end
      OP_VENT_POP_ABT: begin
        act_c = ACT_DELAYED; ch_c = CH_VENT; lvl_c = 1'b1;
        dly_c = POP_MS + ABORT_EXTRA_MS;
      end
      OP_NOS_DLY_OFF: begin
        act_c = ACT_DELAYED; ch_c = CH_NOS; dly_c = 32'(cfg.nos_main_delay_ms);
      end
      OP_IPA_DLY_OFF: begin
        act_c = ACT_DELAYED; ch_c = CH_IPA; dly_c = 32'(cfg.ipa_main_delay_ms);
      end
      OP_PRESS_DLY_NOS: begin
        act_c = ACT_DELAYED; ch_c = CH_PRESS; dly_c = 32'(cfg.nos_main_delay_ms);
      end
      OP_VENT_DLY_IPA: begin
        act_c = ACT_DELAYED; ch_c = CH_VENT; lvl_c = 1'b1;
        dly_c = 32'(cfg.ipa_main_delay_ms);
      end
      default: act_c = ACT_NOW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        idx          <= pop ? '0 : idx + 1'b1;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      action       <= act_c;
      channel      <= ch_c;
      level        <= lvl_c;
      delay_value  <= dly_c;
      abort_code   <= code_c;
      flow_mode    <= fmode_c;
      flow_time    <= ftime_c;
      flow_nitrous <= nit_c;
      flow_ipa     <= ipa_c;
      last         <= (idx == head.cnt);
    end
  end

  assert property (@(posedge clk) disable iff (rst) head_valid |-> idx <= head.cnt)
    else $error("result index past job length");
  assert property (@(posedge clk) disable iff (rst) !head_valid |-> idx == '0)
    else $error("result index left mid job");
  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

[src/engine_launch_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// engine_launch_sequencer
// Five-step engine flow sequencer with APB register port.
// a job passes through the queue before its first result is registered
// throughput: one result per cycle unless stalled; an item yields 1 to 8
// a new transaction is taken each cycle while the job queue has room
// pressure samples yield no result and never enter the queue
// synchronous reset restores step, latched command and register defaults
// ----------------------------------------------------------------------------
module engine_launch_sequencer #(
  parameter int unsigned IGNITION_CHECK_MS = 700,
  parameter int unsigned POPPET_DELAY_MS   = 0,
  parameter int unsigned QUEUE_DEPTH       = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] now_us,
  input  wire logic        igniter_ok,
  input  wire logic        burnwire_ok,
  input  wire logic        breakwire_ok,
  input  wire logic [2:0]  mode,
  input  wire logic [22:0] flow_ms,
  input  wire logic        nitrous_en,
  input  wire logic        ipa_en,
  input  wire logic [19:0] pressure,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [2:0]       action,
  output logic [2:0]       channel,
  output logic             level,
  output logic [31:0]      delay_value,
  output logic [2:0]       abort_code,
  output logic [2:0]       flow_mode,
  output logic [22:0]      flow_time,
  output logic             flow_nitrous,
  output logic             flow_ipa,
  output logic             last
);
  import els_pkg::*;

  cfg_t       cfg;
  job_t       job, head;
  logic       push, accept, q_full, q_nonempty, pop;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cart_variant       <= 1'b0;
      cfg.igniter_timeout_us <= 32'd3000000;
      cfg.burnwire_delay_us  <= 32'd500000;
      cfg.sample_period_us   <= 32'd100000;
      cfg.nos_main_delay_ms  <= 16'd150;
      cfg.ipa_main_delay_ms  <= 16'd110;
      cfg.arm_close_delay_ms <= 16'd2000;
      cfg.pressure_threshold <= 20'd1600;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_CART:      cfg.cart_variant       <= pwdata[0];
        REG_IGN_TMO:   cfg.igniter_timeout_us <= pwdata;
        REG_BURN_DLY:  cfg.burnwire_delay_us  <= pwdata;
        REG_SAMPLE:    cfg.sample_period_us   <= pwdata;
        REG_NOS_DLY:   cfg.nos_main_delay_ms  <= pwdata[15:0];
        REG_IPA_DLY:   cfg.ipa_main_delay_ms  <= pwdata[15:0];
        REG_ARM_DLY:   cfg.arm_close_delay_ms <= pwdata[15:0];
        REG_THRESHOLD: cfg.pressure_threshold <= pwdata[19:0];
        default:       cfg.cart_variant       <= cfg.cart_variant;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CART:      prdata = 32'(cfg.cart_variant);
      REG_IGN_TMO:   prdata = cfg.igniter_timeout_us;
      REG_BURN_DLY:  prdata = cfg.burnwire_delay_us;
      REG_SAMPLE:    prdata = cfg.sample_period_us;
      REG_NOS_DLY:   prdata = 32'(cfg.nos_main_delay_ms);
      REG_IPA_DLY:   prdata = 32'(cfg.ipa_main_delay_ms);
      REG_ARM_DLY:   prdata = 32'(cfg.arm_close_delay_ms);
      REG_THRESHOLD: prdata = 32'(cfg.pressure_threshold);
      default:       prdata = '0;
    endcase
  end

  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;

  els_front #(.IGNITION_CHECK_MS(IGNITION_CHECK_MS)) u_front (
    .clk, .rst, .cfg, .accept, .kind, .now_us, .igniter_ok, .burnwire_ok,
    .breakwire_ok, .mode, .flow_ms, .nitrous_en, .ipa_en, .pressure,
    .job, .push
  );

  els_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .wr(accept && push), .wdata(job), .rd(pop), .rdata(head),
    .full(q_full), .nonempty(q_nonempty)
  );

  els_back #(.POPPET_DELAY_MS(POPPET_DELAY_MS)) u_back (
    .clk, .rst, .cfg, .head, .head_valid(q_nonempty), .pop, .result_valid,
    .result_stall, .action, .channel, .level, .delay_value, .abort_code,
    .flow_mode, .flow_time, .flow_nitrous, .flow_ipa, .last
  );

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for engine_launch_sequencer. A driver feeds launch,
// manual launch, pressure and wake transactions in random bursts; a flow
// predictor builds the expected commands; a monitor checks each result
// transaction in order under a random stall pattern. Registers are rewritten
// over the APB port between phases while the sequencer is idle.
// ----------------------------------------------------------------------------
module testbench;
  import els_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [31:0] IgnCheckUs = 32'd700 * 32'd1000;
  localparam logic [31:0] PoppetMs = 32'd0;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] now;
    logic        ign, burn, brk;
    logic [2:0]  mode;
    logic [22:0] flow;
    logic        nit, ipa;
    logic [19:0] press;
  } cmd_t;

  typedef struct {
    logic [2:0]  act;
    logic [2:0]  ch;
    logic        lvl;
    logic [31:0] dly;
    logic [2:0]  acode;
    logic [2:0]  fmode;
    logic [22:0] ftime;
    logic        fnit, fipa;
    logic        fin;
  } cmd_result_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  wire [31:0] prdata;
  wire pready;
  logic item_valid = 0;
  wire item_stall;
  logic [1:0] kind = 0;
  logic [31:0] now_us = 0;
  logic igniter_ok = 0, burnwire_ok = 0, breakwire_ok = 0;
  logic [2:0] mode = 0;
  logic [22:0] flow_ms = 0;
  logic nitrous_en = 0, ipa_en = 0;
  logic [19:0] pressure = 0;
  wire result_valid;
  logic result_stall = 0;
  wire [2:0] action, channel, abort_code, flow_mode;
  wire level, flow_nitrous, flow_ipa, last;
  wire [31:0] delay_value;
  wire [22:0] flow_time;

  engine_launch_sequencer dut (.*);

  // predictor state and register copy
  logic [2:0] seq_step;
  logic [31:0] seq_start;
  logic [2:0] seq_mode;
  logic [22:0] seq_flow;
  logic seq_nit, seq_ipa, seq_manual;
  logic [19:0] seq_press;
  cfg_t cfg;

  cmd_t pending[$];
  cmd_result_t expected_cmds[$];
  cmd_t cur;
  int errors = 0;
  int cycles = 0;
  int gap_left = 0, burst_left = 0;
  int stall_mode = 0, stall_left = 0;
  logic [31:0] tnow = 0;

  initial forever #10 clk = ~clk;

  function automatic cmd_result_t mk(logic [2:0] a, logic [2:0] c, logic l, logic [31:0] d);
    cmd_result_t r;
    r = '{act: a, ch: c, lvl: l, dly: d, acode: 0, fmode: 0, ftime: 0,
          fnit: 0, fipa: 0, fin: 0};
    return r;
  endfunction

  function automatic cmd_result_t mk_abort(logic [2:0] code);
    cmd_result_t r;
    r = mk(ACT_ABORT, 0, 0, 0);
    r.acode = code;
    r.fmode = seq_mode;
    return r;
  endfunction

  task automatic predict_flow(input cmd_t c);
    cmd_result_t res[$];
    cmd_result_t r;
    logic [31:0] flow_us, el, wake;
    logic ign_mode;
    wake = 0;
    if (c.kind == KIND_PRESS) begin
      seq_press = c.press;
      return;
    end
    if (c.kind == KIND_WAKE) begin
      flow_us = 32'(seq_flow) * 32'd1000;
      ign_mode = seq_mode <= 3'd2;
      case (seq_step)
        STEP_IGNITE: begin
          if (ign_mode) begin
            res.push_back(mk(ACT_NOW, CH_IGN, 1, 0));
            seq_step = STEP_BURN;
            seq_start = c.now;
            wake = cfg.sample_period_us;
          end else begin
            seq_step = STEP_OPEN;
            wake = WAKE_SHORT_US;
          end
        end
        STEP_BURN: begin
          if (c.now - seq_start > cfg.igniter_timeout_us) begin
            res.push_back(mk(ACT_NOW, CH_IGN, 0, 0));
            res.push_back(mk_abort(ABT_BURN_NOT_BURNT));
            seq_step = STEP_IGNITE;
          end else if (!c.burn) begin
            seq_step = STEP_OPEN;
            wake = cfg.burnwire_delay_us;
          end else begin
            wake = cfg.sample_period_us;
          end
        end
        STEP_OPEN: begin
          if (!seq_manual) begin
            if (ign_mode) res.push_back(mk(ACT_NOW, CH_IGN, 0, 0));
            r = mk(ACT_BEGIN, 0, 0, 0);
            r.fmode = seq_mode;
            r.ftime = seq_flow;
            r.fnit = seq_nit;
            r.fipa = seq_ipa;
            res.push_back(r);
          end else begin
            res.push_back(mk(ACT_NOW, CH_IGN, 0, 0));
          end
          if (cfg.cart_variant) begin
            res.push_back(mk(ACT_NOW, CH_ARM, 1, 0));
            if (seq_nit) res.push_back(mk(ACT_DELAYED, CH_NOS, 1, 32'(cfg.nos_main_delay_ms)));
            if (seq_ipa) res.push_back(mk(ACT_DELAYED, CH_IPA, 1, 32'(cfg.ipa_main_delay_ms)));
            seq_nit = 0;
            seq_ipa = 0;
          end else if (seq_nit && seq_ipa) begin
            res.push_back(mk(ACT_DELAYED, CH_PRESS, 0, PoppetMs));
            res.push_back(mk(ACT_DELAYED, CH_VENT, 1, PoppetMs));
            seq_nit = 0;
            seq_ipa = 0;
          end
          seq_manual = 0;
          if (ign_mode) begin
            seq_step = STEP_CHECK;
            seq_start = c.now;
            wake = WAKE_SHORT_US;
          end else begin
            seq_step = STEP_END;
            wake = flow_us;
          end
        end
        STEP_CHECK: begin
          el = c.now - seq_start;
          if (flow_us <= el) begin
            seq_step = STEP_END;
            wake = WAKE_SHORT_US;
          end else if (flow_us < el + cfg.sample_period_us ||
                       seq_press > cfg.pressure_threshold || el > IgnCheckUs) begin
            seq_step = STEP_END;
            wake = flow_us - el;
          end else if (!c.brk) begin
            res.push_back(mk_abort(ABT_BREAK_EARLY));
            if (cfg.cart_variant) begin
              res.push_back(mk(ACT_NOW, CH_ARM, 1, 0));
              res.push_back(mk(ACT_NOW, CH_NOS, 0, 0));
              res.push_back(mk(ACT_NOW, CH_IPA, 0, 0));
              res.push_back(mk(ACT_DELAYED, CH_NOS, 0,
                               32'(cfg.nos_main_delay_ms) + ABORT_EXTRA_MS));
              res.push_back(mk(ACT_DELAYED, CH_IPA, 0,
                               32'(cfg.ipa_main_delay_ms) + ABORT_EXTRA_MS));
              res.push_back(mk(ACT_DELAYED, CH_ARM, 0, 32'(cfg.arm_close_delay_ms)));
            end else begin
              res.push_back(mk(ACT_NOW, CH_PRESS, 0, 0));
              res.push_back(mk(ACT_NOW, CH_VENT, 1, 0));
              res.push_back(mk(ACT_DELAYED, CH_PRESS, 0, PoppetMs + ABORT_EXTRA_MS));
              res.push_back(mk(ACT_DELAYED, CH_VENT, 1, PoppetMs + ABORT_EXTRA_MS));
            end
            seq_step = STEP_IGNITE;
          end else begin
            wake = cfg.sample_period_us;
          end
        end
        STEP_END: begin
          res.push_back(mk(ACT_END, 0, 0, 0));
          if (cfg.cart_variant) begin
            res.push_back(mk(ACT_NOW, CH_ARM, 1, 0));
            res.push_back(mk(ACT_DELAYED, CH_NOS, 0, 32'(cfg.nos_main_delay_ms)));
            res.push_back(mk(ACT_DELAYED, CH_IPA, 0, 32'(cfg.ipa_main_delay_ms)));
            res.push_back(mk(ACT_DELAYED, CH_ARM, 0, 32'(cfg.arm_close_delay_ms)));
          end else begin
            res.push_back(mk(ACT_DELAYED, CH_PRESS, 0, 32'(cfg.nos_main_delay_ms)));
            res.push_back(mk(ACT_DELAYED, CH_VENT, 1, 32'(cfg.ipa_main_delay_ms)));
          end
          seq_step = STEP_IGNITE;
          seq_nit = 0;
          seq_ipa = 0;
        end
        default: wake = 0;
      endcase
      res.push_back(mk(ACT_WAKE, 0, 0, wake));
    end else begin
      seq_mode = c.mode;
      seq_flow = c.flow;
      seq_nit = c.nit;
      seq_ipa = c.ipa;
      ign_mode = seq_mode <= 3'd2;
      if (c.kind == KIND_MANUAL) begin
        seq_step = STEP_OPEN;
        seq_manual = 1;
        res.push_back(mk(ACT_ACCEPT, 0, 0, 0));
      end else if (ign_mode && (!c.ign || !c.burn || !c.brk)) begin
        res.push_back(mk_abort(!c.ign ? ABT_IGNITER : !c.burn ? ABT_BURNWIRE : ABT_BREAKWIRE));
        res.push_back(mk(ACT_REJECT, 0, 0, 0));
      end else begin
        seq_step = STEP_IGNITE;
        res.push_back(mk(ACT_ACCEPT, 0, 0, 0));
      end
    end
    res[res.size()-1].fin = 1;
    foreach (res[i]) expected_cmds.push_back(res[i]);
  endtask

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp, got);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) predict_flow(cur);
      if (!item_valid || !item_stall) begin
        if (gap_left > 0 || pending.size() == 0) begin
          if (gap_left > 0) gap_left--;
          item_valid <= 0;
        end else begin
          cur = pending.pop_front();
          kind <= cur.kind;
          now_us <= cur.now;
          igniter_ok <= cur.ign;
          burnwire_ok <= cur.burn;
          breakwire_ok <= cur.brk;
          mode <= cur.mode;
          flow_ms <= cur.flow;
          nitrous_en <= cur.nit;
          ipa_en <= cur.ipa;
          pressure <= cur.press;
          item_valid <= 1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cmd_result_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t unexpected transaction action %0h", $time, action);
          errors++;
        end else begin
          e = expected_cmds.pop_front();
          check_field("action", e.act, action);
          check_field("channel", e.ch, channel);
          check_field("level", e.lvl, level);
          check_field("delay_value", e.dly, delay_value);
          check_field("abort_code", e.acode, abort_code);
          check_field("flow_mode", e.fmode, flow_mode);
          check_field("flow_time", e.ftime, flow_time);
          check_field("flow_nitrous", e.fnit, flow_nitrous);
          check_field("flow_ipa", e.fipa, flow_ipa);
          check_field("last", e.fin, last);
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(5, 40);
      end else stall_left--;
      case (stall_mode)
        0: result_stall <= 0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        default: result_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  task automatic add(logic [1:0] k, logic [31:0] t, logic ig, logic bu, logic br,
                     logic [2:0] m, logic [22:0] f, logic n, logic i, logic [19:0] p);
    cmd_t c;
    c = '{kind: k, now: t, ign: ig, burn: bu, brk: br, mode: m, flow: f,
          nit: n, ipa: i, press: p};
    pending.push_back(c);
  endtask

  task automatic add_wake(logic bu, logic br);
    tnow += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 250000);
    add(KIND_WAKE, tnow, $urandom_range(0, 1), bu, br, $urandom, $urandom, $urandom,
        $urandom, $urandom);
  endtask

  task automatic add_flow_sequence();
    logic [2:0] m;
    logic [22:0] f;
    int nw;
    m = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(3, 7));
    f = ($urandom_range(0, 4) > 0) ? 23'($urandom_range(0, 1500)) : 23'($urandom);
    add(($urandom_range(0, 4) == 0) ? KIND_MANUAL : KIND_LAUNCH, tnow,
        $urandom_range(0, 9) > 0, $urandom_range(0, 9) > 0, $urandom_range(0, 9) > 0,
        m, f, $urandom, $urandom, $urandom);
    nw = $urandom_range(1, 8);
    for (int j = 0; j < nw; j++) begin
      if ($urandom_range(0, 3) == 0)
        add(KIND_PRESS, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom,
            ($urandom_range(0, 1) == 0) ? 20'($urandom_range(0, 3000)) : 20'($urandom));
      add_wake($urandom_range(0, 1), $urandom_range(0, 9) < 7);
    end
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_CART:      cfg.cart_variant = val[0];
      REG_IGN_TMO:   cfg.igniter_timeout_us = val;
      REG_BURN_DLY:  cfg.burnwire_delay_us = val;
      REG_SAMPLE:    cfg.sample_period_us = val;
      REG_NOS_DLY:   cfg.nos_main_delay_ms = val[15:0];
      REG_IPA_DLY:   cfg.ipa_main_delay_ms = val[15:0];
      REG_ARM_DLY:   cfg.arm_close_delay_ms = val[15:0];
      default:       cfg.pressure_threshold = val[19:0];
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || item_valid || expected_cmds.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [31:0] v[8];
    cfg = '{cart_variant: 0, igniter_timeout_us: 3000000, burnwire_delay_us: 500000,
            sample_period_us: 100000, nos_main_delay_ms: 150, ipa_main_delay_ms: 110,
            arm_close_delay_ms: 2000, pressure_threshold: 1600};
    seq_step = 0; seq_start = 0; seq_mode = 0; seq_flow = 0;
    seq_nit = 0; seq_ipa = 0; seq_manual = 0; seq_press = 20'd14400;
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed: rejects, poppet flow ending in a breakwire abort, manual, timeouts
    add(KIND_LAUNCH, 0, 0, 1, 1, 0, 1000, 1, 1, 0);
    add(KIND_LAUNCH, 0, 1, 0, 1, 1, 1000, 1, 1, 0);
    add(KIND_LAUNCH, 0, 1, 1, 0, 2, 1000, 1, 1, 0);
    add(KIND_PRESS, 0, 0, 0, 0, 0, 0, 0, 0, 20'd0);
    add(KIND_LAUNCH, 0, 1, 1, 1, 0, 1000, 1, 1, 0);
    add(KIND_WAKE, 1000, 1, 1, 1, 0, 0, 0, 0, 0);
    add(KIND_WAKE, 2000, 1, 1, 1, 0, 0, 0, 0, 0);
    add(KIND_WAKE, 3000, 1, 0, 1, 0, 0, 0, 0, 0);
    add(KIND_WAKE, 4000, 1, 0, 1, 0, 0, 0, 0, 0);
    add(KIND_WAKE, 5000, 1, 0, 0, 0, 0, 0, 0, 0);
    add(KIND_LAUNCH, 0, 1, 1, 1, 1, 23'h7fffff, 1, 1, 0);
    add(KIND_WAKE, 32'd10, 1, 1, 1, 0, 0, 0, 0, 0);
    add(KIND_WAKE, 32'hffffffff, 1, 1, 1, 0, 0, 0, 0, 0);
    add(KIND_MANUAL, 0, 0, 0, 0, 7, 0, 0, 1, 0);
    add(KIND_WAKE, 100, 0, 0, 0, 0, 0, 0, 0, 0);
    add(KIND_WAKE, 200, 0, 0, 0, 0, 0, 0, 0, 0);
    add(KIND_LAUNCH, 0, 0, 0, 0, 7, 5, 1, 0, 0);
    add(KIND_WAKE, 300, 1, 1, 1, 0, 0, 0, 0, 0);
    add(KIND_WAKE, 400, 1, 1, 1, 0, 0, 0, 0, 0);
    add(KIND_WAKE, 500, 1, 1, 1, 0, 0, 0, 0, 0);
    add(KIND_PRESS, 32'hffffffff, 1, 1, 1, 7, 23'h7fffff, 1, 1, 20'hfffff);
    add(KIND_LAUNCH, 0, 1, 1, 1, 2, 2000, 0, 1, 0);
    add(KIND_WAKE, 0, 1, 1, 1, 0, 0, 0, 0, 0);
    add(KIND_WAKE, 10, 1, 0, 1, 0, 0, 0, 0, 0);
    add(KIND_WAKE, 20, 1, 0, 0, 0, 0, 0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      for (int r = 0; r < 8; r++) v[r] = $urandom;
      if (ph == 0) v = '{1, 0, 0, 0, 0, 0, 0, 0};
      else if (ph == 1) v = '{0, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                              32'hffff, 32'hffff, 32'hffff, 32'hfffff};
      else if (ph == 2) v = '{1, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                              32'hffff, 32'hffff, 32'hffff, 32'hfffff};
      else begin
        v[0] = ph % 2;
        v[1] = $urandom_range(0, 1000000);
        v[3] = $urandom_range(0, 300000);
        v[7] = $urandom_range(0, 4000);
      end
      for (int r = 0; r < 8; r++) apb_write(3'(r), v[r]);
      for (int r = 0; r < 8; r++) begin
        if ($urandom_range(0, 6) == 0)
          add($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
        else add_flow_sequence();
      end
      wait_idle();
    end

    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
